[hw/rtl/uhpcs_pkg.sv]
// ----------------------------------------------------------------------------
// uhpcs_pkg
// Shared types, codes and helpers of the hub port change sequencer.
// ----------------------------------------------------------------------------
package uhpcs_pkg;

	localparam int MAX_PORTS_DEF  = 15;
	localparam int PORT_W         = 4;
	localparam int ADDR_W         = 7;
	localparam int FEAT_W         = 5;
	localparam int WORD_W         = 16;
	localparam int CFG_DATA_W     = 7;

	localparam logic [PORT_W-1:0] PORT_COUNT_RST  = 4'd4;
	localparam logic [ADDR_W-1:0] HUB_ADDRESS_RST = 7'd1;

	typedef enum logic {
		CFG_PORT_COUNT  = 1'b0,
		CFG_HUB_ADDRESS = 1'b1
	} cfg_idx_t;

	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_INT_DONE  = 2'd1;
	localparam logic [1:0] OP_CTRL_DONE = 2'd2;

	typedef enum logic [2:0] {
		ACT_INT_READ = 3'd0,
		ACT_GET      = 3'd1,
		ACT_SET      = 3'd2,
		ACT_CLEAR    = 3'd3,
		ACT_CLR_ERR  = 3'd4,
		ACT_ATTACH   = 3'd5,
		ACT_DETACH   = 3'd6,
		ACT_RST_WAIT = 3'd7
	} act_t;

	typedef enum logic [2:0] {
		PH_READ,
		PH_READ_WAIT,
		PH_GET,
		PH_GET_WAIT,
		PH_PARSE,
		PH_SET,
		PH_SET_WAIT
	} phase_t;

	localparam int ST_CONNECT_BIT  = 0;
	localparam int ST_ENABLE_BIT   = 1;
	localparam int ST_LOWSPEED_BIT = 9;
	localparam int CH_CONNECT_BIT  = 0;
	localparam int CH_RESET_BIT    = 4;
	localparam logic [3:0] FEAT_RESET = 4'd4;

	typedef struct packed {
		logic [1:0]        opcode;
		logic              accepted;
		logic              transfer_ok;
		logic [WORD_W-1:0] change_bitmap;
		logic [WORD_W-1:0] status_word;
		logic [WORD_W-1:0] port_change;
		logic [ADDR_W-1:0] free_address;
	} item_t;

	typedef struct packed {
		act_t              action;
		logic [PORT_W-1:0] port;
		logic [FEAT_W-1:0] feature;
		logic [ADDR_W-1:0] device_address;
		logic              ls_flag;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] wdata;
	} tbl_req_t;

	function automatic logic [3:0] lowest_bit(input logic [WORD_W-1:0] v);
		logic [3:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = 4'(i);
			end
		end
		return idx;
	endfunction

endpackage

[hw/rtl/uhpcs_dev_tbl.sv]
// ----------------------------------------------------------------------------
// uhpcs_dev_tbl
// Per-port record of attached device addresses, cleared by reset.
// ----------------------------------------------------------------------------
module uhpcs_dev_tbl import uhpcs_pkg::*; #(
	parameter int MAX_PORTS = MAX_PORTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PORT_W-1:0] port,
	input  tbl_req_t          req,
	output logic [ADDR_W-1:0] rdata
);

	localparam int IDX_W = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;

	logic [ADDR_W-1:0] addr_q [MAX_PORTS];
	logic [PORT_W-1:0] raw_idx;
	logic [IDX_W-1:0]  idx;

	// Port n lives in entry n-1; anything out of range folds onto entry zero.
	assign raw_idx = port - 4'd1;
	assign idx = (raw_idx < PORT_W'(MAX_PORTS)) ? raw_idx[IDX_W-1:0] : '0;
	assign rdata = addr_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PORTS; i++) begin
				addr_q[i] <= '0;
			end
		end else if (req.we) begin
			addr_q[idx] <= req.wdata;
		end
	end

endmodule

[hw/rtl/uhpcs_seq.sv]
// ----------------------------------------------------------------------------
// uhpcs_seq
// Phase state machine: consumes one event word per step and gives at most
// one result word.
// ----------------------------------------------------------------------------
module uhpcs_seq import uhpcs_pkg::*; #(
	parameter int MAX_PORTS = MAX_PORTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  item_t             item,
	input  logic [PORT_W-1:0] port_count,
	input  logic [ADDR_W-1:0] hub_address,
	output logic              res_valid,
	output res_t              res
);

	phase_t            phase_q, phase_d;
	logic [WORD_W-1:0] pend_q, pend_d;
	logic [PORT_W-1:0] cur_q, cur_d;
	logic [WORD_W-1:0] clr_q, clr_d;
	logic [WORD_W-1:0] fset_q, fset_d;
	logic [FEAT_W-1:0] afeat_q, afeat_d;
	logic              aset_q, aset_d;
	logic [2*WORD_W-1:0] saved_q, saved_d;

	tbl_req_t          tbl_req;
	logic [ADDR_W-1:0] tbl_rdata;

	logic [PORT_W-1:0] n_ports;
	logic [WORD_W-1:0] port_mask;
	logic [3:0]        lb_pend, lb_clr, lb_fset;
	logic [PORT_W-1:0] cur_eff;
	logic [WORD_W-1:0] st, ch;
	logic              st_live, do_attach, do_detach;
	logic              is_tick;

	uhpcs_dev_tbl #(
		.MAX_PORTS(MAX_PORTS)
	) u_dev_tbl (
		.clk   (clk),
		.arst_n(arst_n),
		.port  (cur_q),
		.req   (tbl_req),
		.rdata (tbl_rdata)
	);

	always_comb begin
		n_ports = (port_count > PORT_W'(MAX_PORTS)) ? PORT_W'(MAX_PORTS) : port_count;
		for (int i = 0; i < WORD_W; i++) begin
			port_mask[i] = (i != 0) && (i <= int'(n_ports));
		end
		lb_pend = lowest_bit(pend_q);
		lb_clr  = lowest_bit(clr_q);
		lb_fset = lowest_bit(fset_q);
		cur_eff = (cur_q == '0) ? lb_pend : cur_q;
		st      = saved_q[WORD_W-1:0];
		ch      = saved_q[2*WORD_W-1:WORD_W];
		is_tick = (item.opcode == OP_TICK);
		st_live = st[ST_CONNECT_BIT] && st[ST_ENABLE_BIT];
		do_detach = ch[CH_CONNECT_BIT] && !st[ST_CONNECT_BIT];
		do_attach = ch[CH_CONNECT_BIT] ? st_live : (ch[CH_RESET_BIT] && st_live);
	end

	always_comb begin
		phase_d = phase_q;
		pend_d  = pend_q;
		cur_d   = cur_q;
		clr_d   = clr_q;
		fset_d  = fset_q;
		afeat_d = afeat_q;
		aset_d  = aset_q;
		saved_d = saved_q;
		tbl_req = '{we: 1'b0, wdata: '0};
		if (step) begin
			case (phase_q)
				PH_READ: begin
					if (is_tick && item.accepted) begin
						phase_d = PH_READ_WAIT;
					end
				end
				PH_READ_WAIT: begin
					if (item.opcode == OP_INT_DONE) begin
						if (!item.transfer_ok) begin
							phase_d = PH_READ;
						end else begin
							pend_d  = item.change_bitmap & port_mask;
							phase_d = ((item.change_bitmap & port_mask) != '0) ? PH_GET : PH_READ;
						end
					end
				end
				PH_GET: begin
					if (is_tick) begin
						if (cur_q == '0 && pend_q == '0) begin
							phase_d = PH_READ;
						end else begin
							if (cur_q == '0) begin
								cur_d = lb_pend;
								pend_d = pend_q & ~(WORD_W'(1) << lb_pend);
							end
							if (item.accepted) begin
								phase_d = PH_GET_WAIT;
							end
						end
					end
				end
				PH_GET_WAIT: begin
					if (item.opcode == OP_CTRL_DONE) begin
						if (!item.transfer_ok) begin
							phase_d = PH_GET;
						end else begin
							saved_d = {item.port_change, item.status_word};
							phase_d = PH_PARSE;
						end
					end
				end
				PH_PARSE: begin
					if (is_tick) begin
						clr_d = ch;
						if (ch == '0) begin
							cur_d   = '0;
							phase_d = PH_READ;
						end else begin
							phase_d = PH_SET;
							if (ch[CH_CONNECT_BIT] && st[ST_CONNECT_BIT] && !st[ST_ENABLE_BIT]) begin
								fset_d = fset_q | (WORD_W'(1) << FEAT_RESET);
							end
							if (do_detach) begin
								tbl_req = '{we: 1'b1, wdata: '0};
							end else if (do_attach) begin
								tbl_req = '{we: 1'b1, wdata: item.free_address};
							end
						end
					end
				end
				PH_SET: begin
					if (is_tick) begin
						if (clr_q == '0 && fset_q == '0) begin
							phase_d = PH_GET;
						end else begin
							if (clr_q != '0) begin
								clr_d   = clr_q & ~(WORD_W'(1) << lb_clr);
								afeat_d = {1'b1, lb_clr};
								aset_d  = 1'b0;
							end else begin
								fset_d  = fset_q & ~(WORD_W'(1) << lb_fset);
								afeat_d = {1'b0, lb_fset};
								aset_d  = 1'b1;
							end
							phase_d = item.accepted ? PH_SET_WAIT : PH_GET;
						end
					end
				end
				PH_SET_WAIT: begin
					if (item.opcode == OP_CTRL_DONE) begin
						phase_d = PH_SET;
						if (!item.transfer_ok) begin
							if (aset_q) begin
								fset_d = fset_q | (WORD_W'(1) << afeat_q[3:0]);
							end else begin
								clr_d = clr_q | (WORD_W'(1) << afeat_q[3:0]);
							end
						end
					end
				end
				default: begin
					phase_d = PH_READ;
				end
			endcase
		end
	end

	always_comb begin
		res_valid = 1'b0;
		res = '{action: ACT_INT_READ, port: '0, feature: '0,
			device_address: hub_address, ls_flag: 1'b0};
		if (step) begin
			case (phase_q)
				PH_READ: begin
					if (is_tick) begin
						res_valid  = 1'b1;
						res.action = item.accepted ? ACT_INT_READ : ACT_CLR_ERR;
					end
				end
				PH_READ_WAIT: begin
					if (item.opcode == OP_INT_DONE && !item.transfer_ok) begin
						res_valid  = 1'b1;
						res.action = ACT_CLR_ERR;
					end
				end
				PH_GET: begin
					if (is_tick && item.accepted && !(cur_q == '0 && pend_q == '0)) begin
						res_valid  = 1'b1;
						res.action = ACT_GET;
						res.port   = cur_eff;
					end
				end
				PH_GET_WAIT: begin
					if (item.opcode == OP_CTRL_DONE && !item.transfer_ok) begin
						res_valid  = 1'b1;
						res.action = ACT_CLR_ERR;
					end
				end
				PH_PARSE: begin
					if (is_tick && ch != '0) begin
						if (do_detach) begin
							res_valid          = 1'b1;
							res.action         = ACT_DETACH;
							res.port           = cur_q;
							res.device_address = tbl_rdata;
						end else if (do_attach) begin
							res_valid          = 1'b1;
							res.action         = ACT_ATTACH;
							res.port           = cur_q;
							res.device_address = item.free_address;
							res.ls_flag        = st[ST_LOWSPEED_BIT];
						end
					end
				end
				PH_SET: begin
					if (is_tick && item.accepted && (clr_q != '0 || fset_q != '0)) begin
						res_valid = 1'b1;
						res.port  = cur_q;
						if (clr_q != '0) begin
							res.action  = ACT_CLEAR;
							res.feature = {1'b1, lb_clr};
						end else begin
							res.action  = ACT_SET;
							res.feature = {1'b0, lb_fset};
						end
					end
				end
				PH_SET_WAIT: begin
					if (item.opcode == OP_CTRL_DONE) begin
						if (!item.transfer_ok) begin
							res_valid  = 1'b1;
							res.action = ACT_CLR_ERR;
						end else if (aset_q && afeat_q == {1'b0, FEAT_RESET}) begin
							res_valid   = 1'b1;
							res.action  = ACT_RST_WAIT;
							res.port    = cur_q;
							res.feature = {1'b0, FEAT_RESET};
						end
					end
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_READ;
			pend_q  <= '0;
			cur_q   <= '0;
			clr_q   <= '0;
			fset_q  <= '0;
			afeat_q <= '0;
			aset_q  <= 1'b0;
			saved_q <= '0;
		end else begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			cur_q   <= cur_d;
			clr_q   <= clr_d;
			fset_q  <= fset_d;
			afeat_q <= afeat_d;
			aset_q  <= aset_d;
			saved_q <= saved_d;
		end
	end

endmodule

[hw/rtl/usb_hub_port_change_sequencer_core.sv]
// ----------------------------------------------------------------------------
// usb_hub_port_change_sequencer_core
// Host-side hub port change sequencer with registered input and result.
// ----------------------------------------------------------------------------
// The block takes one event word per clock cycle while in_stall is low and gives
// at most one result word for it. An accepted word is held in the input register
// until the phase state machine works on it, which it does once the output
// register is empty or being taken; the result is then written into the output
// register, from which it is offered.
// The rate of one word per cycle is set by that single step between the input
// and output registers; a stalled result holds the input register, and the
// input side stalls only when both registers are full.
module usb_hub_port_change_sequencer_core import uhpcs_pkg::*; #(
	parameter int MAX_PORTS = MAX_PORTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            opcode,
	input  logic                  accepted,
	input  logic                  transfer_ok,
	input  logic [WORD_W-1:0]     change_bitmap,
	input  logic [WORD_W-1:0]     status_word,
	input  logic [WORD_W-1:0]     port_change,
	input  logic [ADDR_W-1:0]     free_address,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            action,
	output logic [PORT_W-1:0]     port,
	output logic [FEAT_W-1:0]     feature,
	output logic [ADDR_W-1:0]     device_address,
	output logic                  ls_flag,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic              valid_s1;
	item_t             item_s1;
	logic              adv;
	logic              step;
	logic              res_valid;
	res_t              res;
	logic              out_valid_q;
	res_t              out_q;
	logic [PORT_W-1:0] port_count_q;
	logic [ADDR_W-1:0] hub_address_q;

	assign adv       = !out_valid_q || !out_stall;
	assign step      = valid_s1 && adv;
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_count_q  <= PORT_COUNT_RST;
			hub_address_q <= HUB_ADDRESS_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PORT_COUNT:  port_count_q  <= cfg_data[PORT_W-1:0];
				CFG_HUB_ADDRESS: hub_address_q <= cfg_data[ADDR_W-1:0];
				default: port_count_q <= port_count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= '{opcode: opcode, accepted: accepted, transfer_ok: transfer_ok,
				change_bitmap: change_bitmap, status_word: status_word,
				port_change: port_change, free_address: free_address};
		end
	end

	uhpcs_seq #(
		.MAX_PORTS(MAX_PORTS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (item_s1),
		.port_count (port_count_q),
		.hub_address(hub_address_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign action         = out_q.action;
	assign port           = out_q.port;
	assign feature        = out_q.feature;
	assign device_address = out_q.device_address;
	assign ls_flag        = out_q.ls_flag;

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |=> out_valid)
		else $error("result word was dropped");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled while a register was free");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !valid_s1 |=> !out_valid)
		else $error("result word repeated");

endmodule

[test/tb_usb_hub_port_change_sequencer_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_usb_hub_port_change_sequencer_core
// Self-checking bench for the hub port change sequencer.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own model of the phase machine, the queued change
// bits and features and the per-port device table. Each event word taken by
// the block is run through that model, and every action the model produces
// is matched in order against the result words. A directed opening covers the
// refusals, failures, ignored opcodes, reset, attach and detach paths. Random
// traffic then follows the protocol phases with some noise mixed in, across
// several port counts and hub addresses, with random stalls on both sides, a
// stall-free stretch and a long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_usb_hub_port_change_sequencer_core import uhpcs_pkg::*;;

	localparam int         MAX_PORTS = MAX_PORTS_DEF;
	localparam logic [1:0] OP_RSVD   = 2'd3;
	localparam int         IDLE_PCT  = 26;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            opcode;
	logic                  accepted;
	logic                  transfer_ok;
	logic [WORD_W-1:0]     change_bitmap;
	logic [WORD_W-1:0]     status_word;
	logic [WORD_W-1:0]     port_change;
	logic [ADDR_W-1:0]     free_address;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            action;
	logic [PORT_W-1:0]     port;
	logic [FEAT_W-1:0]     feature;
	logic [ADDR_W-1:0]     device_address;
	logic                  ls_flag;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bit   calm = 1'b0;
	bit   hold_req = 1'b0;
	int   hold_left = 0;
	res_t seen_word;

	class hub_seq_scoreboard;
		phase_t            ph;
		logic [WORD_W-1:0] pending;
		logic [WORD_W-1:0] clr_bits;
		logic [WORD_W-1:0] set_bits;
		logic [PORT_W-1:0] cur;
		logic [FEAT_W-1:0] act_feat;
		logic              act_set;
		logic [31:0]       saved;
		logic [ADDR_W-1:0] dev_tbl [MAX_PORTS];
		logic [PORT_W-1:0] port_count;
		logic [ADDR_W-1:0] hub;
		res_t              due [$];
		int                errors;

		function new();
			ph = PH_READ;
			pending = '0;
			clr_bits = '0;
			set_bits = '0;
			cur = '0;
			act_feat = '0;
			act_set = 1'b0;
			saved = '0;
			foreach (dev_tbl[i]) dev_tbl[i] = '0;
			port_count = PORT_COUNT_RST;
			hub = HUB_ADDRESS_RST;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
			if (idx == CFG_PORT_COUNT) begin
				port_count = v[PORT_W-1:0];
			end else begin
				hub = v[ADDR_W-1:0];
			end
		endfunction

		function logic [3:0] first_set(logic [WORD_W-1:0] v);
			for (int i = 0; i < WORD_W; i++) begin
				if (v[i]) return 4'(i);
			end
			return 4'd0;
		endfunction

		function int slot();
			logic [3:0] i;
			i = cur - 4'd1;
			return (i < MAX_PORTS) ? int'(i) : 0;
		endfunction

		function void post(act_t a, logic [PORT_W-1:0] p, logic [FEAT_W-1:0] f,
				logic [ADDR_W-1:0] d, logic ls);
			res_t r;
			r.action = a;
			r.port = p;
			r.feature = f;
			r.device_address = d;
			r.ls_flag = ls;
			due.push_back(r);
		endfunction

		function void note_word(item_t w);
			int                n;
			logic [WORD_W:0]   span;
			logic [WORD_W-1:0] st;
			logic [WORD_W-1:0] ch;
			logic [3:0]        pos;
			logic [FEAT_W-1:0] feat;
			logic              attach;
			logic [ADDR_W-1:0] old;
			case (ph)
				PH_READ: begin
					if (w.opcode != OP_TICK) return;
					if (w.accepted) begin
						ph = PH_READ_WAIT;
						post(ACT_INT_READ, 0, 0, hub, 0);
					end else begin
						post(ACT_CLR_ERR, 0, 0, hub, 0);
					end
				end
				PH_READ_WAIT: begin
					if (w.opcode != OP_INT_DONE) return;
					if (!w.transfer_ok) begin
						ph = PH_READ;
						post(ACT_CLR_ERR, 0, 0, hub, 0);
						return;
					end
					n = (port_count > MAX_PORTS) ? MAX_PORTS : int'(port_count);
					span = (17'd1 << (n + 1)) - 17'd1;
					pending = w.change_bitmap & span[WORD_W-1:0] & 16'hFFFE;
					ph = (pending != 0) ? PH_GET : PH_READ;
				end
				PH_GET: begin
					if (w.opcode != OP_TICK) return;
					if (cur == 0) begin
						if (pending == 0) begin
							ph = PH_READ;
							return;
						end
						cur = first_set(pending);
						pending[cur] = 1'b0;
					end
					if (!w.accepted) return;
					ph = PH_GET_WAIT;
					post(ACT_GET, cur, 0, hub, 0);
				end
				PH_GET_WAIT: begin
					if (w.opcode != OP_CTRL_DONE) return;
					if (!w.transfer_ok) begin
						ph = PH_GET;
						post(ACT_CLR_ERR, 0, 0, hub, 0);
						return;
					end
					saved = {w.port_change, w.status_word};
					ph = PH_PARSE;
				end
				PH_PARSE: begin
					if (w.opcode != OP_TICK) return;
					st = saved[15:0];
					ch = saved[31:16];
					attach = 1'b0;
					clr_bits = ch;
					if (ch == 0) begin
						cur = '0;
						ph = PH_READ;
						return;
					end
					ph = PH_SET;
					if (ch[CH_CONNECT_BIT]) begin
						if (st[ST_CONNECT_BIT]) begin
							if (st[ST_ENABLE_BIT]) begin
								attach = 1'b1;
							end else begin
								set_bits[FEAT_RESET] = 1'b1;
							end
						end else begin
							old = dev_tbl[slot()];
							dev_tbl[slot()] = '0;
							post(ACT_DETACH, cur, 0, old, 0);
							return;
						end
					end else if (ch[CH_RESET_BIT] && st[ST_CONNECT_BIT] && st[ST_ENABLE_BIT]) begin
						attach = 1'b1;
					end
					if (attach) begin
						dev_tbl[slot()] = w.free_address;
						post(ACT_ATTACH, cur, 0, w.free_address, st[ST_LOWSPEED_BIT]);
					end
				end
				PH_SET: begin
					if (w.opcode != OP_TICK) return;
					if (clr_bits != 0) begin
						pos = first_set(clr_bits);
						clr_bits[pos] = 1'b0;
						feat = {1'b1, pos};
						act_set = 1'b0;
					end else if (set_bits != 0) begin
						pos = first_set(set_bits);
						set_bits[pos] = 1'b0;
						feat = {1'b0, pos};
						act_set = 1'b1;
					end else begin
						ph = PH_GET;
						return;
					end
					act_feat = feat;
					if (!w.accepted) begin
						ph = PH_GET;
						return;
					end
					ph = PH_SET_WAIT;
					post(act_set ? ACT_SET : ACT_CLEAR, cur, feat, hub, 0);
				end
				PH_SET_WAIT: begin
					if (w.opcode != OP_CTRL_DONE) return;
					ph = PH_SET;
					if (!w.transfer_ok) begin
						if (act_set) begin
							set_bits[act_feat[3:0]] = 1'b1;
						end else begin
							clr_bits[act_feat[3:0]] = 1'b1;
						end
						post(ACT_CLR_ERR, 0, 0, hub, 0);
					end else if (act_set && act_feat == {1'b0, FEAT_RESET}) begin
						post(ACT_RST_WAIT, cur, {1'b0, FEAT_RESET}, hub, 0);
					end
				end
				default: ph = PH_READ;
			endcase
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40) $display("%0t mismatch: %s", $realtime, msg);
		endtask

		task check_word(res_t got);
			res_t want;
			if (due.size() == 0) begin
				report($sformatf("result word with nothing expected: action %0d port %0d",
					got.action, got.port));
				return;
			end
			want = due.pop_front();
			if (got.action !== want.action)
				report($sformatf("action %0d, expected %0d", got.action, want.action));
			if (got.port !== want.port)
				report($sformatf("port %0d, expected %0d", got.port, want.port));
			if (got.feature !== want.feature)
				report($sformatf("feature %0d, expected %0d", got.feature, want.feature));
			if (got.device_address !== want.device_address)
				report($sformatf("device_address %0d, expected %0d",
					got.device_address, want.device_address));
			if (got.ls_flag !== want.ls_flag)
				report($sformatf("ls_flag %0b, expected %0b", got.ls_flag, want.ls_flag));
		endtask

		task flush_leftovers();
			res_t r;
			while (due.size() != 0) begin
				r = due.pop_front();
				report($sformatf("expected result never came: action %0d port %0d",
					r.action, r.port));
			end
		endtask
	endclass

	hub_seq_scoreboard sb = new();

	usb_hub_port_change_sequencer_core #(
		.MAX_PORTS(MAX_PORTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.accepted(accepted),
		.transfer_ok(transfer_ok),
		.change_bitmap(change_bitmap),
		.status_word(status_word),
		.port_change(port_change),
		.free_address(free_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.port(port),
		.feature(feature),
		.device_address(device_address),
		.ls_flag(ls_flag),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			seen_word.action = act_t'(action);
			seen_word.port = port;
			seen_word.feature = feature;
			seen_word.device_address = device_address;
			seen_word.ls_flag = ls_flag;
			sb.check_word(seen_word);
		end
		if (hold_req) begin
			hold_left = 80;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic send_word(input item_t w);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= w.opcode;
		accepted <= w.accepted;
		transfer_ok <= w.transfer_ok;
		change_bitmap <= w.change_bitmap;
		status_word <= w.status_word;
		port_change <= w.port_change;
		free_address <= w.free_address;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_word(w);
	endtask

	task automatic send_event(input logic [1:0] op, input logic acc, input logic ok,
			input logic [WORD_W-1:0] bm, input logic [WORD_W-1:0] st,
			input logic [WORD_W-1:0] ch, input logic [ADDR_W-1:0] fa);
		item_t w;
		w.opcode = op;
		w.accepted = acc;
		w.transfer_ok = ok;
		w.change_bitmap = bm;
		w.status_word = st;
		w.port_change = ch;
		w.free_address = fa;
		send_word(w);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	// Words that carry no result may still sit in the pipeline, so the task lets
	// the clock run on after the last expected result before it returns.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic item_t next_word();
		item_t w;
		w.opcode = 2'($urandom_range(0, 3));
		w.accepted = 1'($urandom);
		w.transfer_ok = 1'($urandom);
		w.change_bitmap = 16'($urandom);
		w.status_word = 16'($urandom);
		w.port_change = 16'($urandom);
		w.free_address = 7'($urandom_range(1, 127));
		if ($urandom_range(99) < 15) return w;
		case (sb.ph)
			PH_READ_WAIT: begin
				w.opcode = OP_INT_DONE;
				w.transfer_ok = $urandom_range(99) < 90;
				if ($urandom_range(1)) w.change_bitmap = 16'd1 << $urandom_range(0, 15);
			end
			PH_GET_WAIT: begin
				w.opcode = OP_CTRL_DONE;
				w.transfer_ok = $urandom_range(99) < 90;
				case ($urandom_range(0, 4))
					0: w.port_change = '0;
					1: w.port_change = 16'd1 << CH_CONNECT_BIT;
					2: w.port_change = 16'd1 << CH_RESET_BIT;
					3: w.port_change = w.port_change & 16'h001F;
					default: ;
				endcase
			end
			PH_SET_WAIT: begin
				w.opcode = OP_CTRL_DONE;
				w.transfer_ok = $urandom_range(99) < 85;
			end
			default: begin
				w.opcode = OP_TICK;
				w.accepted = $urandom_range(99) < 88;
			end
		endcase
		return w;
	endfunction

	initial begin
		logic [CFG_DATA_W-1:0] pc;
		logic [CFG_DATA_W-1:0] ha;
		in_valid = 1'b0;
		opcode = OP_TICK;
		accepted = 1'b0;
		transfer_ok = 1'b0;
		change_bitmap = '0;
		status_word = '0;
		port_change = '0;
		free_address = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PORT_COUNT;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_event(OP_RSVD, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
		send_event(OP_TICK, 0, 0, 0, 0, 0, 7'd1);
		send_event(OP_TICK, 1, 0, 0, 0, 0, 7'd1);
		send_event(OP_INT_DONE, 0, 0, 16'hFFFF, 0, 0, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_INT_DONE, 0, 1, 16'hFFE1, 0, 0, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_INT_DONE, 0, 1, 16'h0006, 0, 0, 7'd1);
		send_event(OP_TICK, 0, 1, 0, 0, 0, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_CTRL_DONE, 1, 0, 0, 16'h0001, 16'h0001, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_CTRL_DONE, 1, 1, 0, 16'h0001, 16'h0001, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_CTRL_DONE, 1, 0, 0, 0, 0, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_CTRL_DONE, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_CTRL_DONE, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_CTRL_DONE, 1, 1, 0, 16'h0203, 16'h0010, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd127);
		send_event(OP_TICK, 0, 1, 0, 0, 0, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);
		send_event(OP_CTRL_DONE, 1, 1, 0, 16'h0000, 16'h0001, 7'd1);
		send_event(OP_TICK, 1, 1, 0, 0, 0, 7'd1);

		for (int k = 0; k < 5; k++) begin
			drain();
			case (k)
				0: begin pc = 7'd15; ha = 7'd127; end
				1: begin pc = 7'd1; ha = 7'd1; end
				2: begin pc = 7'd8; ha = 7'd64; end
				default: begin
					pc = 7'($urandom_range(1, 15));
					ha = 7'($urandom_range(1, 127));
				end
			endcase
			write_reg(CFG_PORT_COUNT, pc);
			write_reg(CFG_HUB_ADDRESS, ha);
			if (k == 1) begin
				calm = 1'b1;
				hold_req = 1'b1;
			end
			for (int i = 0; i < 130; i++) begin
				send_word(next_word());
			end
			calm = 1'b0;
		end

		drain();
		repeat (10) @(posedge clk);
		sb.flush_leftovers();
		if (sb.errors == 0) begin
			$display("tb_usb_hub_port_change_sequencer_core: PASS");
		end else begin
			$display("tb_usb_hub_port_change_sequencer_core: FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_usb_hub_port_change_sequencer_core: FAIL");
		$finish;
	end

endmodule
